FILE: rtl/core/ckb_pkg.sv
// ----------------------------------------------------------------------------
// ckb_pkg
// Shared types and constants of the color key blitter: command and register
// codes, sequencer states, clip results and walker controls.
// ----------------------------------------------------------------------------
package ckb_pkg;

  // default geometry
  localparam int FRAME_WIDTH_DEF  = 320;
  localparam int FRAME_HEIGHT_DEF = 240;
  localparam int TEXEL_DEPTH_DEF  = 65536;

  // fixed widths, sized for the largest supported frame (2048 x 2048)
  localparam int COORD_W = 11;   // on-screen coordinate
  localparam int COUNT_W = 12;   // pixels in one row or column of a clipped span
  localparam int LIM_W   = 12;   // frame dimension
  localparam int CALC_W  = 14;   // signed clip arithmetic
  localparam int TEX_W   = 8;    // texture coordinate and pitch
  localparam int TA_W    = 16;   // linear texel address
  localparam int COLOR_W = 16;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_FILL = 2'd1,
    CMD_BLIT = 2'd2,
    CMD_READ = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_TEX_W     = 2'd0,
    REG_TEX_H     = 2'd1,
    REG_KEY_EN    = 2'd2,
    REG_KEY_COLOR = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLIP_COL,
    ST_CLIP_ROW,
    ST_BASE_F,
    ST_BASE_T,
    ST_LOAD_T,
    ST_WALK,
    ST_DRAIN,
    ST_RD_ISSUE,
    ST_RD_OUT
  } state_t;

  // one clipped axis of a rectangle
  typedef struct packed {
    logic               nonempty;
    logic [COORD_W-1:0] start;      // first frame coordinate
    logic [TEX_W-1:0]   tex_start;  // matching texture coordinate
    logic [COUNT_W-1:0] count;      // pixels along this axis
  } clip_t;

  // sequencer to address walker
  typedef struct packed {
    logic mul_frame;  // product of frame row and frame pitch
    logic mul_tex;    // frame base ready, product of texture row and pitch
    logic load;       // texture base ready, clear counters
    logic step;       // advance one pixel
  } walk_ctl_t;

endpackage

FILE: rtl/core/ckb_if.sv
// ----------------------------------------------------------------------------
// ckb_if
// Valid/ready channels of the color key blitter: command items in,
// read results out.
// ----------------------------------------------------------------------------
interface ckb_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [11:0] dest_x;
  logic signed [11:0] dest_y;
  logic [9:0]         span_w;
  logic [9:0]         span_h;
  logic [7:0]         src_x;
  logic [7:0]         src_y;
  logic [15:0]        pixel_value;
  logic [15:0]        texel_index;

  modport source (output valid, cmd, dest_x, dest_y, span_w, span_h, src_x, src_y,
                  pixel_value, texel_index, input ready);
  modport sink (input valid, cmd, dest_x, dest_y, span_w, span_h, src_x, src_y,
                pixel_value, texel_index, output ready);
endinterface

interface ckb_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_color;
  logic        on_screen;

  modport source (output valid, read_color, on_screen, input ready);
  modport sink (input valid, read_color, on_screen, output ready);
endinterface

FILE: rtl/core/ckb_ram.sv
// ----------------------------------------------------------------------------
// ckb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ckb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/ckb_clip.sv
// ----------------------------------------------------------------------------
// ckb_clip
// Shared clip unit: bounds one axis of a fill, blit or read against the
// frame and, for blits, against the texture edge. Used once per axis.
// ----------------------------------------------------------------------------
module ckb_clip import ckb_pkg::*; (
  input  logic signed [11:0] pos,
  input  logic [9:0]         span,
  input  logic [LIM_W-1:0]   lim,
  input  logic [TEX_W-1:0]   tex_lim,
  input  logic [TEX_W-1:0]   tex_pos,
  input  logic               use_tex,
  output clip_t              clip
);

  logic signed [CALC_W-1:0] p;
  logic signed [CALC_W-1:0] c0;
  logic signed [CALC_W-1:0] e_span;
  logic signed [CALC_W-1:0] e_lim;
  logic signed [CALC_W-1:0] e_tex;
  logic signed [CALC_W-1:0] e;
  logic signed [CALC_W-1:0] len;
  logic signed [CALC_W-1:0] skip;
  logic signed [CALC_W-1:0] t0;

  always_comb begin
    p      = CALC_W'(pos);
    c0     = p[CALC_W-1] ? '0 : p;
    e_span = p + signed'(CALC_W'(span));
    e_lim  = signed'(CALC_W'(lim));
    e_tex  = p + signed'(CALC_W'(tex_lim)) - signed'(CALC_W'(tex_pos));

    // end of span: smallest of span end, frame edge and, for blits, texture edge
    e = e_span;
    if (e_lim < e) begin
      e = e_lim;
    end
    if (use_tex && (e_tex < e)) begin
      e = e_tex;
    end

    len  = e - c0;
    skip = c0 - p;
    t0   = signed'(CALC_W'(tex_pos)) + skip;

    clip.nonempty  = (e > c0);
    clip.start     = c0[COORD_W-1:0];
    clip.tex_start = t0[TEX_W-1:0];
    clip.count     = len[COUNT_W-1:0];
  end

endmodule

FILE: rtl/core/ckb_walk.sv
// ----------------------------------------------------------------------------
// ckb_walk
// Address walker: forms frame and texel row bases with one shared multiplier,
// then steps both addresses one pixel per cycle across the clipped rectangle.
// ----------------------------------------------------------------------------
module ckb_walk import ckb_pkg::*; #(
  parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  walk_ctl_t                                    ctl,
  input  clip_t                                        col,
  input  clip_t                                        row,
  input  logic [TEX_W-1:0]                             pitch,
  output logic [$clog2(FRAME_WIDTH*FRAME_HEIGHT)-1:0]  frame_addr,
  output logic [TA_W-1:0]                              tex_addr,
  output logic                                         last
);

  localparam int FA_W   = $clog2(FRAME_WIDTH*FRAME_HEIGHT);
  localparam int PROD_W = COORD_W + LIM_W;

  logic [PROD_W-1:0]  prod;
  logic [COORD_W-1:0] mul_a;
  logic [LIM_W-1:0]   mul_b;
  logic [FA_W-1:0]    frame_row;
  logic [FA_W-1:0]    frame_row_next;
  logic [FA_W-1:0]    frame_base;
  logic [TA_W-1:0]    tex_row;
  logic [TA_W-1:0]    tex_row_next;
  logic [TA_W-1:0]    tex_base;
  logic [COUNT_W-1:0] col_cnt;
  logic [COUNT_W-1:0] row_cnt;
  logic               col_last;

  // shared multiplier operands
  always_comb begin
    if (ctl.mul_tex) begin
      mul_a = COORD_W'(row.tex_start);
      mul_b = LIM_W'(pitch);
    end else begin
      mul_a = row.start;
      mul_b = LIM_W'(FRAME_WIDTH);
    end
  end

  assign frame_base     = prod[FA_W-1:0] + FA_W'(col.start);
  assign tex_base       = prod[TA_W-1:0] + TA_W'(col.tex_start);
  assign frame_row_next = frame_row + FA_W'(FRAME_WIDTH);
  assign tex_row_next   = tex_row + TA_W'(pitch);
  assign col_last       = (COUNT_W'(col_cnt + 1'b1) == col.count);
  assign last           = col_last && (COUNT_W'(row_cnt + 1'b1) == row.count);

  // product register
  always_ff @(posedge clk) begin
    if (ctl.mul_frame || ctl.mul_tex) begin
      prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
  end

  // address registers
  always_ff @(posedge clk) begin
    if (ctl.mul_tex) begin
      frame_row  <= frame_base;
      frame_addr <= frame_base;
    end else if (ctl.load) begin
      tex_row  <= tex_base;
      tex_addr <= tex_base;
    end else if (ctl.step) begin
      if (col_last) begin
        frame_row  <= frame_row_next;
        frame_addr <= frame_row_next;
        tex_row    <= tex_row_next;
        tex_addr   <= tex_row_next;
      end else begin
        frame_addr <= frame_addr + 1'b1;
        tex_addr   <= tex_addr + 1'b1;
      end
    end
  end

  // pixel counters
  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (ctl.load) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (ctl.step) begin
      if (col_last) begin
        col_cnt <= '0;
        row_cnt <= row_cnt + 1'b1;
      end else begin
        col_cnt <= col_cnt + 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/color_key_blitter.sv
// ----------------------------------------------------------------------------
// color_key_blitter
// RGB565 2D blitter with its own frame store and texel store: texel load,
// clipped rectangle fill, color keyed blit and pixel read.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    cmd, dest_x, dest_y, span_w, span_h, src_x,
//                                src_y, pixel_value, texel_index
//   out_ch   out  valid/ready    read_color, on_screen
//   cfg      in   cfg_we         cfg_idx, cfg_data
//
// A texel load is written on accept. Fill and blit step through column clip,
// row clip, frame base, texture base, counter load, one walk step per pixel
// and a drain; with nothing on screen they end after frame base. A read gets
// its address through the clip unit, one multiplier pass and the registered
// frame store read, then its output step; off screen it skips the read.
// One item at a time: ready is low while an item is worked on, and a read
// waits in its last step while the output register is still full.
// Reset is synchronous; the stores are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module color_key_blitter import ckb_pkg::*; #(
  parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF,
  parameter int TEXEL_DEPTH  = TEXEL_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  ckb_in_if.sink           in_ch,
  ckb_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_idx,
  input  logic [15:0]      cfg_data
);

  localparam int FA_W  = $clog2(FRAME_WIDTH*FRAME_HEIGHT);
  localparam int TXA_W = $clog2(TEXEL_DEPTH);

  state_t state;
  state_t state_next;

  // configuration
  logic [TEX_W-1:0]   tex_w;
  logic [TEX_W-1:0]   tex_h;
  logic               key_en;
  logic [COLOR_W-1:0] key_color;

  // current item
  cmd_t               cur_cmd;
  logic signed [11:0] cur_x;
  logic signed [11:0] cur_y;
  logic [9:0]         cur_w;
  logic [9:0]         cur_h;
  logic [TEX_W-1:0]   cur_sx;
  logic [TEX_W-1:0]   cur_sy;
  logic [COLOR_W-1:0] cur_color;

  logic               accept;
  logic               tex_we;
  logic               tex_re;
  logic [COLOR_W-1:0] tex_rdata;
  logic               frame_we;
  logic               frame_re;
  logic [COLOR_W-1:0] frame_rdata;
  logic [COLOR_W-1:0] frame_wdata;
  logic               keyed;

  // clip unit
  logic               col_pass;
  logic signed [11:0] clip_pos;
  logic [9:0]         clip_span;
  clip_t              clip_res;
  clip_t              col_clip;
  clip_t              row_clip;
  logic               visible;

  // walker
  walk_ctl_t          walk_ctl;
  logic [FA_W-1:0]    frame_addr;
  logic [TA_W-1:0]    tex_addr;
  logic               walk_last;

  // pending frame write, registered alongside the texel read data
  logic               pend_valid;
  logic [FA_W-1:0]    pend_fa;
  logic               pend_skip;

  // output register
  logic               out_valid;
  logic [COLOR_W-1:0] out_color;
  logic               out_on;
  logic               out_free;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid || out_ch.ready;
  assign visible  = col_clip.nonempty && row_clip.nonempty;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      tex_w     <= TEX_W'(1);
      tex_h     <= TEX_W'(1);
      key_en    <= 1'b0;
      key_color <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_TEX_W:     tex_w     <= cfg_data[TEX_W-1:0];
        REG_TEX_H:     tex_h     <= cfg_data[TEX_W-1:0];
        REG_KEY_EN:    key_en    <= cfg_data[0];
        REG_KEY_COLOR: key_color <= cfg_data;
        default:       ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_cmd   <= cmd_t'(in_ch.cmd);
      cur_x     <= in_ch.dest_x;
      cur_y     <= in_ch.dest_y;
      cur_w     <= in_ch.span_w;
      cur_h     <= in_ch.span_h;
      cur_sx    <= in_ch.src_x;
      cur_sy    <= in_ch.src_y;
      cur_color <= in_ch.pixel_value;
    end
  end

  // texel store: loads go straight in on accept
  assign tex_we = accept && (cmd_t'(in_ch.cmd) == CMD_LOAD)
                  && ({1'b0, in_ch.texel_index} < 17'(TEXEL_DEPTH));
  assign tex_re = (state == ST_WALK) && (cur_cmd == CMD_BLIT);

  ckb_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (TEXEL_DEPTH)
  ) u_texel_ram (
    .clk   (clk),
    .we    (tex_we),
    .waddr (in_ch.texel_index[TXA_W-1:0]),
    .wdata (in_ch.pixel_value),
    .re    (tex_re),
    .raddr (tex_addr[TXA_W-1:0]),
    .rdata (tex_rdata)
  );

  // shared clip unit, column pass then row pass
  assign col_pass  = (state == ST_CLIP_COL);
  assign clip_pos  = col_pass ? cur_x : cur_y;
  assign clip_span = (cur_cmd == CMD_READ) ? 10'd1 : (col_pass ? cur_w : cur_h);

  ckb_clip u_clip (
    .pos     (clip_pos),
    .span    (clip_span),
    .lim     (col_pass ? LIM_W'(FRAME_WIDTH) : LIM_W'(FRAME_HEIGHT)),
    .tex_lim (col_pass ? tex_w : tex_h),
    .tex_pos (col_pass ? cur_sx : cur_sy),
    .use_tex (cur_cmd == CMD_BLIT),
    .clip    (clip_res)
  );

  always_ff @(posedge clk) begin
    if (state == ST_CLIP_COL) begin
      col_clip <= clip_res;
    end
    if (state == ST_CLIP_ROW) begin
      row_clip <= clip_res;
    end
  end

  ckb_walk #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_walk (
    .clk        (clk),
    .rst        (rst),
    .ctl        (walk_ctl),
    .col        (col_clip),
    .row        (row_clip),
    .pitch      (tex_w),
    .frame_addr (frame_addr),
    .tex_addr   (tex_addr),
    .last       (walk_last)
  );

  // pending write stage
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else begin
      pend_valid <= (state == ST_WALK);
    end
  end

  always_ff @(posedge clk) begin
    pend_fa   <= frame_addr;
    pend_skip <= ({1'b0, tex_addr} >= 17'(TEXEL_DEPTH));
  end

  // keyed or out-of-store texels are dropped on blits
  assign keyed       = (cur_cmd == CMD_BLIT)
                       && (pend_skip || (key_en && (tex_rdata == key_color)));
  assign frame_wdata = (cur_cmd == CMD_BLIT) ? tex_rdata : cur_color;
  assign frame_we    = pend_valid && !keyed;
  assign frame_re    = (state == ST_RD_ISSUE);

  ckb_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (FRAME_WIDTH*FRAME_HEIGHT)
  ) u_frame_ram (
    .clk   (clk),
    .we    (frame_we),
    .waddr (pend_fa),
    .wdata (frame_wdata),
    .re    (frame_re),
    .raddr (frame_addr),
    .rdata (frame_rdata)
  );

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer next state and controls
  always_comb begin
    state_next   = state;
    walk_ctl     = '0;
    in_ch.ready  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid && (cmd_t'(in_ch.cmd) != CMD_LOAD)) begin
          state_next = ST_CLIP_COL;
        end
      end
      ST_CLIP_COL: state_next = ST_CLIP_ROW;
      ST_CLIP_ROW: state_next = ST_BASE_F;
      ST_BASE_F: begin
        walk_ctl.mul_frame = 1'b1;
        if (visible) begin
          state_next = ST_BASE_T;
        end else if (cur_cmd == CMD_READ) begin
          state_next = ST_RD_OUT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_BASE_T: begin
        walk_ctl.mul_tex = 1'b1;
        state_next = (cur_cmd == CMD_READ) ? ST_RD_ISSUE : ST_LOAD_T;
      end
      ST_LOAD_T: begin
        walk_ctl.load = 1'b1;
        state_next = ST_WALK;
      end
      ST_WALK: begin
        walk_ctl.step = 1'b1;
        if (walk_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN:    state_next = ST_IDLE;
      ST_RD_ISSUE: state_next = ST_RD_OUT;
      ST_RD_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_RD_OUT) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_RD_OUT) && out_free) begin
      out_color <= visible ? frame_rdata : '0;
      out_on    <= visible;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.read_color = out_color;
  assign out_ch.on_screen  = out_on;

  // a frame write only trails a walk step
  a_write_after_walk: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> ($past(state) == ST_WALK))
    else $error("frame write without a walk step");

  // a new result only comes from a read item
  a_result_from_read: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (($past(state) == ST_RD_OUT) && (cur_cmd == CMD_READ)))
    else $error("result not caused by a read");

  // an off-screen read reports black
  a_offscreen_black: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_on) |-> (out_color == '0))
    else $error("off-screen read with nonzero color");

endmodule

FILE: tb/color_key_blitter_tb.sv
// ----------------------------------------------------------------------------
// color_key_blitter_tb
// Self-checking bench for the color key blitter. A short table of directed
// commands covers the frame edges, clipping, rejected blits and off-screen
// reads. Random command streams follow, run under a series of texture and
// key settings, with random stalls on both channels. A local model of the frame
// and texel stores predicts random read results, the table gives directed ones.
// ----------------------------------------------------------------------------
module color_key_blitter_tb;
  import ckb_pkg::*;

  localparam int FW              = FRAME_WIDTH_DEF;
  localparam int FH              = FRAME_HEIGHT_DEF;
  localparam int TD              = TEXEL_DEPTH_DEF;
  localparam int NUM_PHASES      = 10;
  localparam int ITEMS_PER_PHASE = 120;
  localparam int PRESSURE_PHASE  = 5;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_BASE     = 16;
  localparam int BIG_FILL        = 4096;

  // texture and key settings, one per phase; a negative key means random
  localparam int PHASE_TW [NUM_PHASES]     = '{8, 255, 1, 0, 16, 13, 255, 32, 5, 20};
  localparam int PHASE_TH [NUM_PHASES]     = '{8, 1, 255, 4, 0, 7, 2, 16, 60, 20};
  localparam int PHASE_KEY_EN [NUM_PHASES] = '{1, 0, 1, 1, 0, 1, 1, 1, 0, 1};
  localparam int PHASE_KEY [NUM_PHASES]    = '{0, 'hFFFF, 'hFFFF, -1, -1, -1, -1, -1, -1, -1};

  typedef struct {
    cmd_t               cmd;
    logic signed [11:0] dx;
    logic signed [11:0] dy;
    logic [9:0]         w;
    logic [9:0]         h;
    logic [7:0]         sx;
    logic [7:0]         sy;
    logic [15:0]        pv;
    logic [15:0]        ti;
    bit                 typed;
    logic [15:0]        want_color;
    bit                 want_on;
  } cmd_item_t;

  typedef struct packed {
    logic [15:0] color;
    logic        visible;
  } read_result_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [15:0] cfg_data;

  ckb_in_if  cmd_ch ();
  ckb_out_if res_ch ();

  color_key_blitter dut (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (cmd_ch),
    .out_ch   (res_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // model of the block state
  logic [15:0] frame_mdl [FW*FH];
  logic [15:0] texel_mdl [TD];
  int          tex_pitch = 1;
  int          tex_rows  = 1;
  bit          key_on    = 1'b0;
  logic [15:0] key_rgb   = 16'h0000;
  int          last_work = 0;

  // stimulus bookkeeping
  bit          texel_set [TD];
  int          recent_x = 0;
  int          recent_y = 0;
  int          big_fills_left = 3;
  int          feed_calm = 0;
  int          sink_calm = 0;
  bit          hold_off_req = 1'b0;
  bit          dir_typed = 1'b0;
  logic [15:0] dir_color = 16'h0000;
  bit          dir_on = 1'b0;
  int          errors = 0;

  read_result_t pending_reads [$];
  cmd_item_t    script [$];

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #60_000_000;
    $display("color_key_blitter test failed");
    $finish;
  end

  task automatic report_mismatch(input string what);
    errors++;
    $display("ERROR at %0t: %s", $time, what);
  endtask

  // pixels of one axis that fall inside [0, lim)
  function automatic int clip_span(input int pos, input int len, input int lim);
    int lo, hi;
    lo = (pos < 0) ? 0 : pos;
    hi = (pos + len > lim) ? lim : pos + len;
    return (hi > lo) ? hi - lo : 0;
  endfunction

  // idle length for either side, with stretches of no idling
  function automatic int idle_len(inout int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 99) == 0) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // apply one command to the model, give the read result if any
  task automatic run_command(input cmd_item_t it, output bit has_res,
                             output read_result_t res);
    int x, y, w, h, tx, ty, i, j, i0, i1, j0, j1, addr;
    logic [15:0] c;
    x = it.dx;
    y = it.dy;
    w = it.w;
    h = it.h;
    tx = it.sx;
    ty = it.sy;
    has_res = 1'b0;
    res = '0;
    last_work = 0;
    case (it.cmd)
      CMD_LOAD: begin
        texel_mdl[it.ti] = it.pv;
      end
      CMD_FILL: begin
        i0 = (x < 0) ? 0 : x;
        j0 = (y < 0) ? 0 : y;
        i1 = (x + w > FW) ? FW : x + w;
        j1 = (y + h > FH) ? FH : y + h;
        for (j = j0; j < j1; j++)
          for (i = i0; i < i1; i++)
            frame_mdl[j*FW + i] = it.pv;
        last_work = clip_span(x, w, FW) * clip_span(y, h, FH);
      end
      CMD_BLIT: begin
        // rejected when the corner is past the frame or outside the texture
        if (x < FW && y < FH && tx < tex_pitch && ty < tex_rows) begin
          i0 = (x < 0) ? -x : 0;
          j0 = (y < 0) ? -y : 0;
          i1 = w;
          if (FW - x < i1) i1 = FW - x;
          if (tex_pitch - tx < i1) i1 = tex_pitch - tx;
          j1 = h;
          if (FH - y < j1) j1 = FH - y;
          if (tex_rows - ty < j1) j1 = tex_rows - ty;
          for (j = j0; j < j1; j++) begin
            for (i = i0; i < i1; i++) begin
              addr = (tx + i) + (ty + j) * tex_pitch;
              if (addr < TD) begin
                c = texel_mdl[addr];
                if (!(key_on && c == key_rgb))
                  frame_mdl[(y + j)*FW + x + i] = c;
              end
            end
          end
          if (i1 > i0 && j1 > j0) last_work = (i1 - i0) * (j1 - j0);
        end
      end
      default: begin
        has_res = 1'b1;
        if (x >= 0 && y >= 0 && x < FW && y < FH) begin
          res.color = frame_mdl[y*FW + x];
          res.visible = 1'b1;
        end
      end
    endcase
  endtask

  // texel value, often the current key color
  function automatic logic [15:0] texel_value();
    return ($urandom_range(0, 3) == 0) ? key_rgb : 16'($urandom);
  endfunction

  // one random command, mostly well formed for the current texture
  function automatic cmd_item_t make_item();
    cmd_item_t it;
    int r, area;
    it.cmd = cmd_t'(2'($urandom_range(0, 3)));
    it.dx = 12'($urandom);
    it.dy = 12'($urandom);
    it.w = 10'($urandom);
    it.h = 10'($urandom);
    it.sx = 8'($urandom);
    it.sy = 8'($urandom);
    it.pv = 16'($urandom);
    it.ti = 16'($urandom);
    it.typed = 1'b0;
    it.want_color = '0;
    it.want_on = 1'b0;
    area = tex_pitch * tex_rows;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      // noise: every field random, only a few large on-screen fills
      if (it.cmd == CMD_FILL &&
          clip_span(it.dx, it.w, FW) * clip_span(it.dy, it.h, FH) > BIG_FILL) begin
        if (big_fills_left > 0) big_fills_left--;
        else begin
          it.w[9:5] = '0;
          it.h[9:5] = '0;
        end
      end
    end else if (r < 28) begin
      it.cmd = CMD_LOAD;
      if (area > 0 && $urandom_range(0, 3) != 0) it.ti = 16'($urandom_range(0, area - 1));
      it.pv = texel_value();
    end else if (r < 43) begin
      it.cmd = CMD_FILL;
      it.dx = 12'(int'($urandom_range(0, 360)) - 20);
      it.dy = 12'(int'($urandom_range(0, 280)) - 20);
      it.w = 10'($urandom_range(0, 24));
      it.h = 10'($urandom_range(0, 24));
      recent_x = it.dx;
      recent_y = it.dy;
    end else if (r < 73) begin
      it.cmd = CMD_BLIT;
      if (tex_pitch > 0 && $urandom_range(0, 7) != 0)
        it.sx = 8'($urandom_range(0, tex_pitch - 1));
      if (tex_rows > 0 && $urandom_range(0, 7) != 0)
        it.sy = 8'($urandom_range(0, tex_rows - 1));
      it.dx = 12'(int'($urandom_range(0, tex_pitch + 340)) - tex_pitch - 10);
      it.dy = 12'(int'($urandom_range(0, tex_rows + 260)) - tex_rows - 10);
      if ($urandom_range(0, 7) != 0) begin
        it.w = 10'($urandom_range(0, tex_pitch + 4));
        it.h = 10'($urandom_range(0, tex_rows + 4));
      end
      recent_x = it.dx;
      recent_y = it.dy;
    end else begin
      it.cmd = CMD_READ;
      if ($urandom_range(0, 1) == 0) begin
        it.dx = 12'(recent_x + int'($urandom_range(0, 20)) - 2);
        it.dy = 12'(recent_y + int'($urandom_range(0, 12)) - 2);
      end else begin
        it.dx = 12'(int'($urandom_range(0, 330)) - 5);
        it.dy = 12'(int'($urandom_range(0, 250)) - 5);
      end
    end
    if (it.cmd == CMD_LOAD) texel_set[it.ti] = 1'b1;
    return it;
  endfunction

  // directed table rows
  task automatic op_row(input cmd_t c, input int x, input int y, input int w, input int h,
                        input int sx, input int sy, input int pv, input int ti);
    cmd_item_t it;
    it.cmd = c;
    it.dx = 12'(x);
    it.dy = 12'(y);
    it.w = 10'(w);
    it.h = 10'(h);
    it.sx = 8'(sx);
    it.sy = 8'(sy);
    it.pv = 16'(pv);
    it.ti = 16'(ti);
    it.typed = 1'b0;
    it.want_color = '0;
    it.want_on = 1'b0;
    if (c == CMD_LOAD) texel_set[it.ti] = 1'b1;
    script.push_back(it);
  endtask

  task automatic read_row(input int x, input int y, input int color, input bit on);
    cmd_item_t it;
    it.cmd = CMD_READ;
    it.dx = 12'(x);
    it.dy = 12'(y);
    it.w = '0;
    it.h = '0;
    it.sx = '0;
    it.sy = '0;
    it.pv = '0;
    it.ti = '0;
    it.typed = 1'b1;
    it.want_color = 16'(color);
    it.want_on = on;
    script.push_back(it);
  endtask

  // offer one item and wait until it is taken
  task automatic send_item(input cmd_item_t it);
    int gap;
    gap = idle_len(feed_calm);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.cmd <= it.cmd;
    cmd_ch.dest_x <= it.dx;
    cmd_ch.dest_y <= it.dy;
    cmd_ch.span_w <= it.w;
    cmd_ch.span_h <= it.h;
    cmd_ch.src_x <= it.sx;
    cmd_ch.src_y <= it.sy;
    cmd_ch.pixel_value <= it.pv;
    cmd_ch.texel_index <= it.ti;
    dir_typed <= it.typed;
    dir_color <= it.want_color;
    dir_on <= it.want_on;
    cmd_ch.valid <= 1'b1;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    case (idx)
      REG_TEX_W:  tex_pitch = data[7:0];
      REG_TEX_H:  tex_rows = data[7:0];
      REG_KEY_EN: key_on = data[0];
      default:    key_rgb = data;
    endcase
    @(negedge clk);
  endtask

  // all reads back, then time for a fill or blit still being walked
  task automatic wait_idle();
    cmd_ch.valid <= 1'b0;
    while (pending_reads.size() != 0) @(negedge clk);
    repeat (SETTLE_BASE + last_work) @(negedge clk);
  endtask

  // accepted items: update the model and queue the expected read result
  always @(posedge clk) begin : accept_mon
    cmd_item_t    it;
    bit           has_res;
    read_result_t got;
    if (!rst && cmd_ch.valid && cmd_ch.ready) begin
      it.cmd = cmd_t'(cmd_ch.cmd);
      it.dx = cmd_ch.dest_x;
      it.dy = cmd_ch.dest_y;
      it.w = cmd_ch.span_w;
      it.h = cmd_ch.span_h;
      it.sx = cmd_ch.src_x;
      it.sy = cmd_ch.src_y;
      it.pv = cmd_ch.pixel_value;
      it.ti = cmd_ch.texel_index;
      run_command(it, has_res, got);
      if (has_res) begin
        if (dir_typed) begin
          got.color = dir_color;
          got.visible = dir_on;
        end
        pending_reads.push_back(got);
      end
    end
  end

  // read results against the oldest expectation
  always @(posedge clk) begin : result_mon
    read_result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_reads.size() == 0) begin
        report_mismatch($sformatf("unexpected read result color %h on_screen %b",
                                  res_ch.read_color, res_ch.on_screen));
      end else begin
        want = pending_reads.pop_front();
        if (res_ch.read_color !== want.color)
          report_mismatch($sformatf("read_color %h, expected %h",
                                    res_ch.read_color, want.color));
        if (res_ch.on_screen !== want.visible)
          report_mismatch($sformatf("on_screen %b, expected %b",
                                    res_ch.on_screen, want.visible));
      end
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin : result_sink
    int n;
    res_ch.ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (hold_off_req) begin
        n = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end else begin
        n = idle_len(sink_calm);
      end
      if (n > 0) begin
        res_ch.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  end

  // stimulus
  initial begin : stimulus
    cmd_item_t it;
    int p, a;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_idx = REG_TEX_W;
    cfg_data = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.cmd = CMD_LOAD;
    cmd_ch.dest_x = '0;
    cmd_ch.dest_y = '0;
    cmd_ch.span_w = '0;
    cmd_ch.span_h = '0;
    cmd_ch.src_x = '0;
    cmd_ch.src_y = '0;
    cmd_ch.pixel_value = '0;
    cmd_ch.texel_index = '0;

    // directed table, run with the reset settings (1 x 1 texture, no key)
    op_row(CMD_FILL, -5, -5, 1023, 1023, 0, 0, 'h1234, 0);  // whole frame
    read_row(0, 0, 'h1234, 1'b1);
    read_row(319, 239, 'h1234, 1'b1);
    read_row(-1, 0, 0, 1'b0);
    read_row(320, 5, 0, 1'b0);
    read_row(0, 240, 0, 1'b0);
    read_row(-2048, -2048, 0, 1'b0);
    read_row(2047, 2047, 0, 1'b0);
    op_row(CMD_FILL, 10, 10, 0, 5, 0, 0, 'hFFFF, 0);        // zero size
    read_row(10, 10, 'h1234, 1'b1);
    op_row(CMD_FILL, 316, 236, 8, 8, 0, 0, 'hFFFF, 0);      // clipped at corner
    read_row(319, 239, 'hFFFF, 1'b1);
    read_row(315, 239, 'h1234, 1'b1);
    op_row(CMD_LOAD, 0, 0, 0, 0, 0, 0, 'hABCD, 0);
    op_row(CMD_LOAD, 0, 0, 0, 0, 0, 0, 'h5A5A, 'hFFFF);
    op_row(CMD_BLIT, 20, 20, 1, 1, 0, 0, 0, 0);
    read_row(20, 20, 'hABCD, 1'b1);
    op_row(CMD_BLIT, 30, 30, 5, 5, 0, 0, 0, 0);              // window past texture
    read_row(31, 30, 'h1234, 1'b1);
    read_row(30, 31, 'h1234, 1'b1);
    op_row(CMD_BLIT, 40, 40, 1, 1, 1, 0, 0, 0);              // source outside texture
    read_row(40, 40, 'h1234, 1'b1);
    op_row(CMD_BLIT, 319, 239, 1023, 1023, 0, 0, 0, 0);      // window past frame
    read_row(319, 239, 'hABCD, 1'b1);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (script[k]) send_item(script[k]);

    // texel setup items carry no geometry
    it.dx = '0;
    it.dy = '0;
    it.w = '0;
    it.h = '0;
    it.sx = '0;
    it.sy = '0;
    it.want_color = '0;
    it.want_on = 1'b0;

    // random phases, each with its own texture and key settings
    for (p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      write_reg(REG_TEX_W, 16'(PHASE_TW[p]));
      write_reg(REG_TEX_H, 16'(PHASE_TH[p]));
      write_reg(REG_KEY_EN, 16'(PHASE_KEY_EN[p]));
      write_reg(REG_KEY_COLOR, (PHASE_KEY[p] < 0) ? 16'($urandom) : 16'(PHASE_KEY[p]));
      cfg_we <= 1'b0;
      if (p == PRESSURE_PHASE) hold_off_req = 1'b1;
      // every texel the new pitch can reach gets written before any blit
      for (a = 0; a < tex_pitch * tex_rows; a++) begin
        if (!texel_set[a]) begin
          it.cmd = CMD_LOAD;
          it.ti = 16'(a);
          it.pv = texel_value();
          it.typed = 1'b0;
          texel_set[a] = 1'b1;
          send_item(it);
        end
      end
      repeat (ITEMS_PER_PHASE) send_item(make_item());
    end

    wait_idle();
    if (errors == 0) begin
      $display("color_key_blitter test passed");
    end else begin
      $display("color_key_blitter test failed");
    end
    $finish;
  end

endmodule
